// ===== hw/rtl/ws2812_spi_frame_encoder_defines.svh =====
// ----------------------------------------------------------------------------
// ws2812 spi frame encoder assertion macros
// assertion helpers for the encoder's back sequencer (wsf_back)
// ----------------------------------------------------------------------------
`ifndef WS2812_SPI_FRAME_ENCODER_DEFINES_SVH
`define WS2812_SPI_FRAME_ENCODER_DEFINES_SVH

// same-cycle implication
`define WSF_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define WSF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/wsf_pkg.sv =====
// ----------------------------------------------------------------------------
// wsf_pkg
// constants, types and line-coding function for the ws2812 spi encoder
// ----------------------------------------------------------------------------
package wsf_pkg;

   localparam int LED_COUNT     = 9;
   localparam int RESET_BYTES   = 24;
   localparam int BYTES_PER_LED = 9;
   localparam int COLOUR_W      = 8;
   localparam int BYTE_W        = 8;
   localparam int CODE_W        = 3 * COLOUR_W;
   localparam int DATA_W        = BYTES_PER_LED * BYTE_W;
   localparam int POS_W         = 10;
   localparam int CNT_W         = 5;
   localparam int QUEUE_DEPTH   = 2;
   localparam int QPTR_W        = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

   localparam logic [2:0] ONE_CODE  = 3'b110;
   localparam logic [2:0] ZERO_CODE = 3'b100;

   localparam logic             HAS_RESET  = (RESET_BYTES != 0);
   localparam logic [POS_W-1:0] LED_LIMIT  = POS_W'(LED_COUNT);
   localparam logic [CNT_W-1:0] RST_LAST   = CNT_W'((RESET_BYTES == 0) ? 0 : RESET_BYTES - 1);
   localparam logic [CNT_W-1:0] BYTE_LAST  = CNT_W'(BYTES_PER_LED - 1);

   typedef struct packed {
      logic [DATA_W-1:0] data;
      logic              lead;
      logic              trail;
   } desc_type;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_LEAD  = 4'b0010,
      ST_DATA  = 4'b0100,
      ST_TRAIL = 4'b1000
   } back_state_type;

   function automatic logic [CODE_W-1:0] code_colour(input logic [COLOUR_W-1:0] v);
      logic [CODE_W-1:0] res;
      res = '0;
      for (int i = 0; i < COLOUR_W; i++) begin
         res[CODE_W-1-3*i -: 3] = v[COLOUR_W-1-i] ? ONE_CODE : ZERO_CODE;
      end
      return res;
   endfunction

endpackage

// ===== hw/rtl/wsf_if.sv =====
// ----------------------------------------------------------------------------
// wsf_if
// request and response channel interfaces of the ws2812 spi encoder
// ----------------------------------------------------------------------------
interface wsf_req_if import wsf_pkg::*;;
   logic                valid;
   logic                ready;
   logic [COLOUR_W-1:0] red;
   logic [COLOUR_W-1:0] green;
   logic [COLOUR_W-1:0] blue;

   modport source (output valid, output red, output green, output blue, input ready);
   modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface wsf_rsp_if import wsf_pkg::*;;
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] spi_byte;
   logic              frame_last;

   modport source (output valid, output spi_byte, output frame_last, input ready);
   modport sink   (input valid, input spi_byte, input frame_last, output ready);
endinterface

// ===== hw/rtl/ws2812_spi_frame_encoder.sv =====
// ----------------------------------------------------------------------------
// ws2812_spi_frame_encoder
// turns led colour requests into the line-coded spi byte stream of a chain
// ----------------------------------------------------------------------------
// Each request carries one LED colour and yields nine response bytes (green,
// red, blue, MSB first, each bit sent as 110 or 100). The first LED of a frame
// is preceded by RESET_BYTES zero bytes and the LED_COUNT-th is followed by
// RESET_BYTES zero bytes, the final one flagged with frame_last. One response
// byte leaves per clock from the output register while rsp_ch.ready is high,
// so an LED sends nine bytes, plus RESET_BYTES for the first and for the last
// LED of a frame. A two-entry queue lets a new request be taken while the
// previous LED is still being sent.
module ws2812_spi_frame_encoder import wsf_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   wsf_req_if.sink   req_ch,
   wsf_rsp_if.source rsp_ch
);

   logic     push_valid;
   logic     push_ready;
   desc_type push_desc;
   logic     pop_valid;
   logic     pop_ready;
   desc_type pop_desc;

   wsf_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .push_valid (push_valid),
      .push_desc  (push_desc),
      .push_ready (push_ready)
   );

   wsf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_desc  (push_desc),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_desc   (pop_desc),
      .pop_ready  (pop_ready)
   );

   wsf_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_desc  (pop_desc),
      .pop_ready (pop_ready),
      .rsp_ch    (rsp_ch)
   );

endmodule

// ===== hw/rtl/wsf_front.sv =====
// ----------------------------------------------------------------------------
// wsf_front
// accepts led requests, tracks chain position and line-codes the colour
// ----------------------------------------------------------------------------
module wsf_front import wsf_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   wsf_req_if.sink       req_ch,
   output logic          push_valid,
   output desc_type      push_desc,
   input  logic          push_ready
);

   logic [POS_W-1:0] pos_ff;
   logic [POS_W-1:0] pos_in;
   logic [POS_W-1:0] pos_next;
   logic             end_frame;
   logic             accept;

   assign req_ch.ready = push_ready;
   assign push_valid   = req_ch.valid;
   assign accept       = req_ch.valid && push_ready;

   assign pos_next  = pos_ff + POS_W'(1);
   assign end_frame = (pos_next == '0) || (pos_next >= LED_LIMIT);

   always_comb begin
      push_desc.data  = {code_colour(req_ch.green), code_colour(req_ch.red),
                         code_colour(req_ch.blue)};
      push_desc.lead  = (pos_ff == '0);
      push_desc.trail = end_frame;
      pos_in          = pos_ff;
      if (accept) begin
         pos_in = end_frame ? '0 : pos_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else begin
         pos_ff <= pos_in;
      end
   end

endmodule

// ===== hw/rtl/wsf_queue.sv =====
// ----------------------------------------------------------------------------
// wsf_queue
// short request queue between the front and back sections
// ----------------------------------------------------------------------------
module wsf_queue import wsf_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push_valid,
   input  desc_type push_desc,
   output logic     push_ready,
   output logic     pop_valid,
   output desc_type pop_desc,
   input  logic     pop_ready
);

   desc_type            mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff;
   logic [QPTR_W-1:0]   wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff;
   logic [QPTR_W-1:0]   rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff;
   logic [QCNT_W-1:0]   count_in;
   logic                push;
   logic                pop;

   assign push_ready = (count_ff != QCNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_desc   = mem_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + QPTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + QPTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_desc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== hw/rtl/wsf_back.sv =====
// ----------------------------------------------------------------------------
// wsf_back
// byte sequencer: leading reset, nine data bytes, trailing reset
// ----------------------------------------------------------------------------
`include "ws2812_spi_frame_encoder_defines.svh"

module wsf_back import wsf_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     pop_valid,
   input  desc_type pop_desc,
   output logic     pop_ready,
   wsf_rsp_if.source rsp_ch
);

   back_state_type    state_ff;
   back_state_type    state_in;
   back_state_type    step_state;
   logic [CNT_W-1:0]  cnt_ff;
   logic [CNT_W-1:0]  cnt_in;
   logic [CNT_W-1:0]  step_cnt;
   logic [DATA_W-1:0] data_ff;
   logic [DATA_W-1:0] data_in;
   logic [DATA_W-1:0] step_data;
   logic              trail_ff;
   logic              trail_in;
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   logic [BYTE_W-1:0] rsp_byte_ff;
   logic [BYTE_W-1:0] rsp_byte_in;
   logic              rsp_last_ff;
   logic              rsp_last_in;
   logic [BYTE_W-1:0] step_byte;
   logic              step_last;
   logic              item_done;
   logic              advance;
   logic              load;

   assign advance   = (state_ff != ST_IDLE) && (!rsp_valid_ff || rsp_ch.ready);
   assign pop_ready = (state_ff == ST_IDLE) || (advance && item_done);
   assign load      = pop_valid && pop_ready;

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.spi_byte   = rsp_byte_ff;
   assign rsp_ch.frame_last = rsp_last_ff;

   always_comb begin
      step_state = state_ff;
      step_cnt   = cnt_ff;
      step_data  = data_ff;
      step_byte  = '0;
      step_last  = 1'b0;
      item_done  = 1'b0;
      case (state_ff)
         ST_LEAD: begin
            if (cnt_ff == RST_LAST) begin
               step_state = ST_DATA;
               step_cnt   = '0;
            end else begin
               step_cnt = cnt_ff + CNT_W'(1);
            end
         end
         ST_DATA: begin
            step_byte = data_ff[DATA_W-1 -: BYTE_W];
            step_data = {data_ff[DATA_W-BYTE_W-1:0], {BYTE_W{1'b0}}};
            step_last = !HAS_RESET && trail_ff && (cnt_ff == BYTE_LAST);
            if (cnt_ff == BYTE_LAST) begin
               step_cnt = '0;
               if (trail_ff && HAS_RESET) begin
                  step_state = ST_TRAIL;
               end else begin
                  item_done = 1'b1;
               end
            end else begin
               step_cnt = cnt_ff + CNT_W'(1);
            end
         end
         ST_TRAIL: begin
            step_last = (cnt_ff == RST_LAST);
            if (cnt_ff == RST_LAST) begin
               item_done = 1'b1;
            end else begin
               step_cnt = cnt_ff + CNT_W'(1);
            end
         end
         default: begin
            step_state = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      data_in      = data_ff;
      trail_in     = trail_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_last_in  = rsp_last_ff;
      if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (advance) begin
         rsp_valid_in = 1'b1;
         rsp_byte_in  = step_byte;
         rsp_last_in  = step_last;
         state_in     = item_done ? ST_IDLE : step_state;
         cnt_in       = step_cnt;
         data_in      = step_data;
      end
      if (load) begin
         state_in = (pop_desc.lead && HAS_RESET) ? ST_LEAD : ST_DATA;
         cnt_in   = '0;
         data_in  = pop_desc.data;
         trail_in = pop_desc.trail;
      end
   end

   always_ff @(posedge clock) begin
      data_ff     <= data_in;
      trail_ff    <= trail_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_last_ff <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // leading reset bytes never close a frame
   `WSF_ASSERT_NEXT(a_lead_not_last, clock, reset, advance && (state_ff == ST_LEAD), !rsp_last_ff, "lead byte marked last")
   // data byte counter stays inside one led
   `WSF_ASSERT_IMPL(a_data_cnt, clock, reset, state_ff == ST_DATA, cnt_ff <= BYTE_LAST, "data count overrun")
   // final trailing byte is marked
   `WSF_ASSERT_NEXT(a_trail_last, clock, reset, advance && (state_ff == ST_TRAIL) && (cnt_ff == RST_LAST), rsp_valid_ff && rsp_last_ff, "frame end not marked")

endmodule

// ===== bench/tb_ws2812_spi_frame_encoder.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_ws2812_spi_frame_encoder
// self-checking bench for the ws2812 spi frame encoder
// ----------------------------------------------------------------------------
// Drives LED colour requests into the encoder and checks every line-coded
// SPI byte and its frame_last flag against an in-bench model of the framing:
// leading zero bytes on the first LED, nine GRB-coded bytes per LED, trailing
// zero bytes and the last-byte mark after the final LED of a chain. A short
// table of directed colours comes first, then randomised colours. Both sides
// insert random gaps, with some stretches at full rate.
// ----------------------------------------------------------------------------
module tb_ws2812_spi_frame_encoder import wsf_pkg::*; ();

   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int RANDOM_LEDS  = 458;
   localparam int DRAIN_CYCLES = 64;
   localparam int MAX_REPORTS  = 10;

   typedef struct packed {
      logic [BYTE_W-1:0] spi_byte;
      logic              frame_last;
   } line_byte_type;

   typedef struct packed {
      logic [COLOUR_W-1:0] red;
      logic [COLOUR_W-1:0] green;
      logic [COLOUR_W-1:0] blue;
      logic                typed;
      logic [DATA_W-1:0]   coded;
   } led_row_type;

   logic clock;
   logic reset;

   wsf_req_if req_ch ();
   wsf_rsp_if rsp_ch ();

   ws2812_spi_frame_encoder uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // chain position as the encoder should see it
   logic [POS_W-1:0] chain_pos;
   line_byte_type    spi_expect_q [$];
   line_byte_type    want;

   int unsigned cycle_count;
   int unsigned fault_count;
   int unsigned leds_sent;
   int unsigned bytes_seen;
   int unsigned frames_seen;
   int unsigned rsp_hold;
   int unsigned rsp_draw;
   bit          quiet_run;

   // directed colours; coded data given where it is plain to see
   led_row_type dir_rows [0:11] = '{
      '{8'h00, 8'h00, 8'h00, 1'b1, 72'h924924_924924_924924},
      '{8'hFF, 8'hFF, 8'hFF, 1'b1, 72'hDB6DB6_DB6DB6_DB6DB6},
      '{8'hFF, 8'h00, 8'h00, 1'b1, 72'h924924_DB6DB6_924924},
      '{8'h00, 8'hFF, 8'h00, 1'b1, 72'hDB6DB6_924924_924924},
      '{8'h00, 8'h00, 8'hFF, 1'b1, 72'h924924_924924_DB6DB6},
      '{8'h80, 8'h01, 8'h80, 1'b0, 72'h0},
      '{8'h01, 8'h80, 8'h01, 1'b0, 72'h0},
      '{8'hAA, 8'h55, 8'hAA, 1'b0, 72'h0},
      '{8'h55, 8'hAA, 8'h55, 1'b0, 72'h0},
      '{8'h12, 8'h34, 8'h56, 1'b0, 72'h0},
      '{8'hFE, 8'h7F, 8'hEF, 1'b0, 72'h0},
      '{8'h0F, 8'hF0, 8'h3C, 1'b0, 72'h0}
   };

   always #4 clock = ~clock;

   function automatic logic [CODE_W-1:0] line_code(input logic [COLOUR_W-1:0] v);
      logic [CODE_W-1:0] acc;
      acc = '0;
      for (int b = COLOUR_W - 1; b >= 0; b--) begin
         acc = {acc[CODE_W-4:0], (v[b] ? ONE_CODE : ZERO_CODE)};
      end
      return acc;
   endfunction

   // queue the bytes one accepted LED should produce
   function automatic void queue_led_bytes(input logic [DATA_W-1:0] coded);
      bit            end_of_chain;
      line_byte_type beat;
      if (chain_pos == '0) begin
         for (int i = 0; i < RESET_BYTES; i++) begin
            beat = '{spi_byte: '0, frame_last: 1'b0};
            spi_expect_q.push_back(beat);
         end
      end
      chain_pos    = chain_pos + 1'b1;
      end_of_chain = (chain_pos == '0) || (chain_pos >= LED_LIMIT);
      for (int k = 0; k < BYTES_PER_LED; k++) begin
         beat.spi_byte   = coded[DATA_W-1-BYTE_W*k -: BYTE_W];
         beat.frame_last = end_of_chain && (RESET_BYTES == 0) && (k == BYTES_PER_LED - 1);
         spi_expect_q.push_back(beat);
      end
      if (end_of_chain) begin
         for (int i = 0; i < RESET_BYTES; i++) begin
            beat = '{spi_byte: '0, frame_last: (i == RESET_BYTES - 1)};
            spi_expect_q.push_back(beat);
         end
         chain_pos = '0;
      end
   endfunction

   function automatic void flag_fault(input string msg);
      fault_count++;
      if (fault_count <= MAX_REPORTS) begin
         $display("mismatch at cycle %0d: %s", cycle_count, msg);
      end
   endfunction

   function automatic logic [COLOUR_W-1:0] pick_colour();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return '1;
         default: return COLOUR_W'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic send_led(input led_row_type row, input int unsigned gap);
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.red   <= row.red;
      req_ch.green <= row.green;
      req_ch.blue  <= row.blue;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      if (row.typed) begin
         queue_led_bytes(row.coded);
      end else begin
         queue_led_bytes({line_code(row.green), line_code(row.red), line_code(row.blue)});
      end
      leds_sent++;
   endtask

   task automatic wait_drained();
      while (spi_expect_q.size() != 0) @(posedge clock);
   endtask

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d bytes outstanding", cycle_count,
                  spi_expect_q.size());
         $display("[ws2812_spi_frame_encoder] ERROR");
         $finish;
      end
   end

   // response side: random stalls and byte checking
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         rsp_hold     <= 0;
      end else if (rsp_ch.valid && rsp_ch.ready) begin
         bytes_seen++;
         if (rsp_ch.frame_last) frames_seen++;
         if (spi_expect_q.size() == 0) begin
            flag_fault($sformatf("unexpected byte %02h last %0b", rsp_ch.spi_byte,
                                 rsp_ch.frame_last));
         end else begin
            want = spi_expect_q.pop_front();
            if (want.spi_byte !== rsp_ch.spi_byte) begin
               flag_fault($sformatf("spi_byte expected %02h actual %02h", want.spi_byte,
                                    rsp_ch.spi_byte));
            end
            if (want.frame_last !== rsp_ch.frame_last) begin
               flag_fault($sformatf("frame_last expected %0b actual %0b", want.frame_last,
                                    rsp_ch.frame_last));
            end
         end
         rsp_draw = quiet_run ? 0 : $urandom_range(0, 7);
         if (rsp_draw == 0) begin
            rsp_ch.ready <= 1'b1;
         end else begin
            rsp_ch.ready <= 1'b0;
            rsp_hold     <= rsp_draw - 1;
         end
      end else if (!rsp_ch.ready) begin
         if (rsp_hold == 0) begin
            rsp_ch.ready <= 1'b1;
         end else begin
            rsp_hold <= rsp_hold - 1;
         end
      end
   end

   initial begin
      led_row_type row;
      clock        = 1'b0;
      reset        = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.red   = '0;
      req_ch.green = '0;
      req_ch.blue  = '0;
      rsp_ch.ready = 1'b0;
      chain_pos    = '0;
      cycle_count  = 0;
      fault_count  = 0;
      leds_sent    = 0;
      bytes_seen   = 0;
      frames_seen  = 0;
      quiet_run    = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i]) begin
         send_led(dir_rows[i], $urandom_range(0, 7));
      end

      for (int i = 0; i < RANDOM_LEDS; i++) begin
         // full-rate stretches on both sides
         quiet_run <= (i >= 60 && i < 120) || (i >= 300 && i < 350);
         if (i % 150 == 75) begin
            req_ch.valid <= 1'b0;
            wait_drained();
         end
         row.red   = pick_colour();
         row.green = pick_colour();
         row.blue  = pick_colour();
         row.typed = 1'b0;
         row.coded = '0;
         send_led(row, ((i >= 60 && i < 120) || (i >= 300 && i < 350)) ? 0 :
                       $urandom_range(0, 7));
      end
      req_ch.valid <= 1'b0;

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (spi_expect_q.size() != 0) begin
         flag_fault($sformatf("%0d bytes never arrived", spi_expect_q.size()));
      end

      $display("sent %0d leds, checked %0d spi bytes over %0d complete frames",
               leds_sent, bytes_seen, frames_seen);
      $display("random gaps and stalls on both channels, %0d mismatches", fault_count);
      if (fault_count == 0) begin
         $display("[ws2812_spi_frame_encoder] OK");
      end else begin
         $display("[ws2812_spi_frame_encoder] ERROR");
      end
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/wsf_pkg.sv
hw/rtl/wsf_if.sv
hw/rtl/wsf_front.sv
hw/rtl/wsf_queue.sv
hw/rtl/wsf_back.sv
hw/rtl/ws2812_spi_frame_encoder.sv
bench/tb_ws2812_spi_frame_encoder.sv
